// ===== hw/rtl/one_wire_bus_master_top_macros.svh =====
// Assertion macros used by the 1-Wire bus master engine.
`ifndef ONE_WIRE_BUS_MASTER_TOP_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_TOP_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define OWBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define OWBM_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

// ===== hw/rtl/owbm_pkg.sv =====
// Types and constants of the 1-Wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       line_in;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       device_present;
    logic       command_rejected;
  } res_item_t;

  // Item as classified by the front end.
  typedef struct packed {
    logic       is_cmd;
    op_e        op;
    logic [7:0] data_byte;
    logic       line_in;
  } fe_item_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_RECOV   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SLOT          = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_ONE_LOW = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_READ_LOW      = 3'd5;

  localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd60;
  localparam logic [9:0] RESET_RECOV_DEF   = 10'd480;
  localparam logic [7:0] SLOT_DEF          = 8'd60;
  localparam logic [3:0] WRITE_ONE_LOW_DEF = 4'd1;
  localparam logic [3:0] READ_LOW_DEF      = 4'd2;

endpackage

// ===== hw/rtl/one_wire_bus_master_top.sv =====
// Path: input items are registered in the front queue, results in the result queue.
// Throughput: one item per cycle while the result queue has room; the engine retires
// one tick or command each cycle and the two-entry queues on either side absorb stalls.
// Reset: asynchronous, active low; clears the queues and bus state and restores the
// default timing registers. Bus timing is counted in tick items, not clock cycles.
`timescale 1ns / 1ps

module one_wire_bus_master_top
  import owbm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  in_item_t            in_item_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output res_item_t           res_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic      fe_valid;
  fe_item_t  fe_item;
  logic      fe_take;
  logic      res_valid;
  res_item_t res_item;
  logic      res_ready;

  owbm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .in_item_i    (in_item_i),
    .full_o       (full),
    .item_valid_o (fe_valid),
    .item_o       (fe_item),
    .item_take_i  (fe_take)
  );

  owbm_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (fe_valid),
    .item_i       (fe_item),
    .item_take_o  (fe_take),
    .res_valid_o  (res_valid),
    .res_item_o   (res_item),
    .res_ready_i  (res_ready)
  );

  owbm_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_item_i  (res_item),
    .res_ready_o (res_ready),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_item_o  (res_item_o)
  );

endmodule

// ===== hw/rtl/owbm_front.sv =====
// Front end: accepts input items, classifies them and queues them for the engine.
`timescale 1ns / 1ps

module owbm_front
  import owbm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_item_i,
  output logic     full_o,
  output logic     item_valid_o,
  output fe_item_t item_o,
  input  logic     item_take_i
);

  fe_item_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;
  fe_item_t   cls_item;

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign wr_en        = push_i && !full_o;
  assign rd_en        = item_take_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    cls_item.op        = op_e'(in_item_i.operation);
    cls_item.is_cmd    = (op_e'(in_item_i.operation) != OP_TICK);
    cls_item.data_byte = in_item_i.data_byte;
    cls_item.line_in   = in_item_i.line_in;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

// ===== hw/rtl/owbm_engine.sv =====
// Back end: bus timing engine that carries out ticks and commands, one item a cycle while the result queue has room.
`timescale 1ns / 1ps
`include "one_wire_bus_master_top_macros.svh"

module owbm_engine
  import owbm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                item_valid_i,
  input  fe_item_t            item_i,
  output logic                item_take_o,
  output logic                res_valid_o,
  output res_item_t           res_item_o,
  input  logic                res_ready_i
);

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_RST_LOW   = 7'b0000010,
    PH_RST_WAIT  = 7'b0000100,
    PH_RST_RECOV = 7'b0001000,
    PH_BIT_LOW   = 7'b0010000,
    PH_SAMPLE    = 7'b0100000,
    PH_BIT_REL   = 7'b1000000
  } phase_e;

  localparam logic [16:0] TMax = 17'((1 << TIMER_WIDTH) - 1);

  function automatic logic [TIMER_WIDTH-1:0] tmr_load(input logic [9:0] v);
    logic [16:0]            vx;
    logic [TIMER_WIDTH-1:0] r;
    vx = {7'b0, v};
    if (vx > TMax) begin
      r = TMax[TIMER_WIDTH-1:0];
    end else begin
      r = vx[TIMER_WIDTH-1:0];
    end
    if (v == 10'd0) begin
      r = TIMER_WIDTH'(1);
    end
    return r;
  endfunction

  logic [9:0] rst_low_q, rst_recov_q;
  logic [7:0] pres_wait_q, slot_q;
  logic [3:0] w1_low_q, rd_low_q;

  phase_e                 phase_q, phase_d;
  op_e                    cmd_q, cmd_d;
  logic [TIMER_WIDTH-1:0] tmr_q, tmr_d;
  logic [2:0]             bitpos_q, bitpos_d;
  logic [7:0]             shift_q, shift_d;
  logic                   pres_q, pres_d;
  logic [7:0]             last_rd_q, last_rd_d;

  logic                   take;
  logic [TIMER_WIDTH-1:0] tmr_dec;
  logic                   expired;
  logic [7:0]             nb_shift;
  logic [TIMER_WIDTH-1:0] nb_timer;
  logic [TIMER_WIDTH-1:0] start_timer;
  logic                   do_next;
  logic                   done;
  logic                   rejected;

  assign take        = item_valid_i && res_ready_i;
  assign item_take_o = take;
  assign res_valid_o = take;

  assign tmr_dec = (tmr_q != '0) ? (tmr_q - TIMER_WIDTH'(1)) : '0;
  assign expired = (tmr_dec == '0);

  // Next bit of a byte: writes shift down, reads keep the assembled bits.
  assign nb_shift = (cmd_q == OP_WRITE) ? {1'b0, shift_q[7:1]} : shift_q;
  assign nb_timer = (cmd_q == OP_WRITE)
                  ? (nb_shift[0] ? tmr_load({6'b0, w1_low_q}) : tmr_load({2'b0, slot_q}))
                  : tmr_load({6'b0, rd_low_q});
  assign start_timer = (item_i.op == OP_WRITE)
                     ? (item_i.data_byte[0] ? tmr_load({6'b0, w1_low_q})
                                            : tmr_load({2'b0, slot_q}))
                     : tmr_load({6'b0, rd_low_q});

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    tmr_d     = tmr_q;
    bitpos_d  = bitpos_q;
    shift_d   = shift_q;
    pres_d    = pres_q;
    last_rd_d = last_rd_q;
    do_next   = 1'b0;
    done      = 1'b0;
    rejected  = 1'b0;

    if (take) begin
      if (!item_i.is_cmd) begin
        unique case (phase_q)
          PH_IDLE: begin
          end
          PH_RST_LOW: begin
            tmr_d = tmr_dec;
            if (expired) begin
              phase_d = PH_RST_WAIT;
              tmr_d   = tmr_load({2'b0, pres_wait_q});
            end
          end
          PH_RST_WAIT: begin
            tmr_d = tmr_dec;
            if (expired) begin
              pres_d  = !item_i.line_in;
              phase_d = PH_RST_RECOV;
              tmr_d   = tmr_load(rst_recov_q);
            end
          end
          PH_RST_RECOV: begin
            tmr_d = tmr_dec;
            if (expired) begin
              phase_d = PH_IDLE;
              tmr_d   = '0;
              done    = 1'b1;
            end
          end
          PH_BIT_LOW: begin
            tmr_d = tmr_dec;
            if (expired) begin
              if (cmd_q == OP_WRITE) begin
                if (shift_q[0]) begin
                  phase_d = PH_BIT_REL;
                  tmr_d   = tmr_load({2'b0, slot_q});
                end else begin
                  do_next = 1'b1;
                end
              end else begin
                phase_d = PH_SAMPLE;
              end
            end
          end
          PH_SAMPLE: begin
            shift_d = {item_i.line_in, shift_q[7:1]};
            phase_d = PH_BIT_REL;
            tmr_d   = tmr_load({2'b0, slot_q});
          end
          PH_BIT_REL: begin
            tmr_d = tmr_dec;
            if (expired) begin
              do_next = 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase

        if (do_next) begin
          if (bitpos_q == 3'd7) begin
            phase_d = PH_IDLE;
            tmr_d   = '0;
            done    = 1'b1;
            if (cmd_q == OP_READ) begin
              last_rd_d = shift_q;
            end
          end else begin
            bitpos_d = bitpos_q + 3'd1;
            shift_d  = nb_shift;
            phase_d  = PH_BIT_LOW;
            tmr_d    = nb_timer;
          end
        end
      end else if (phase_q != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        cmd_d    = item_i.op;
        bitpos_d = 3'd0;
        if (item_i.op == OP_RESET) begin
          phase_d = PH_RST_LOW;
          tmr_d   = tmr_load(rst_low_q);
        end else begin
          shift_d = (item_i.op == OP_WRITE) ? item_i.data_byte : 8'd0;
          phase_d = PH_BIT_LOW;
          tmr_d   = start_timer;
        end
      end
    end
  end

  always_comb begin
    res_item_o.drive_low        = (phase_d == PH_RST_LOW) || (phase_d == PH_BIT_LOW);
    res_item_o.busy_res         = (phase_d != PH_IDLE);
    res_item_o.done_res         = done;
    res_item_o.read_data        = last_rd_d;
    res_item_o.device_present   = pres_d;
    res_item_o.command_rejected = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_low_q   <= RESET_LOW_DEF;
      pres_wait_q <= PRESENCE_WAIT_DEF;
      rst_recov_q <= RESET_RECOV_DEF;
      slot_q      <= SLOT_DEF;
      w1_low_q    <= WRITE_ONE_LOW_DEF;
      rd_low_q    <= READ_LOW_DEF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RESET_LOW:     rst_low_q   <= cfg_data_i;
        CFG_PRESENCE_WAIT: pres_wait_q <= cfg_data_i[7:0];
        CFG_RESET_RECOV:   rst_recov_q <= cfg_data_i;
        CFG_SLOT:          slot_q      <= cfg_data_i[7:0];
        CFG_WRITE_ONE_LOW: w1_low_q    <= cfg_data_i[3:0];
        CFG_READ_LOW:      rd_low_q    <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cmd_q     <= OP_TICK;
      tmr_q     <= '0;
      bitpos_q  <= 3'd0;
      shift_q   <= 8'd0;
      pres_q    <= 1'b0;
      last_rd_q <= 8'd0;
    end else begin
      phase_q   <= phase_d;
      cmd_q     <= cmd_d;
      tmr_q     <= tmr_d;
      bitpos_q  <= bitpos_d;
      shift_q   <= shift_d;
      pres_q    <= pres_d;
      last_rd_q <= last_rd_d;
    end
  end

  `OWBM_ASSERT(a_cmd_starts, (take && item_i.is_cmd && phase_q == PH_IDLE) |=> (phase_q != PH_IDLE), "command taken while idle did not start an operation")
  `OWBM_ASSERT(a_done_idles, (take && done) |=> (phase_q == PH_IDLE), "operation completed but engine left idle")
  `OWBM_ASSERT_NEVER(a_reject_idle, rejected && (phase_q == PH_IDLE), "command rejected while idle")
  `OWBM_ASSERT(a_timer_live, (phase_q == PH_RST_LOW || phase_q == PH_RST_WAIT || phase_q == PH_RST_RECOV || phase_q == PH_BIT_LOW || phase_q == PH_BIT_REL) |-> (tmr_q != '0), "timer empty in a timed phase")

endmodule

// ===== hw/rtl/owbm_out_queue.sv =====
// Result queue: holds result items until the consumer pops them.
`timescale 1ns / 1ps

module owbm_out_queue
  import owbm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  input  res_item_t res_item_i,
  output logic      res_ready_o,
  output logic      empty_o,
  input  logic      pop_i,
  output res_item_t res_item_o
);

  res_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign res_ready_o = (cnt_q != 2'd2);
  assign empty_o     = (cnt_q == 2'd0);
  assign wr_en       = res_valid_i && res_ready_o;
  assign rd_en       = pop_i && !empty_o;
  assign res_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= res_item_i;
    end
  end

endmodule
